@@ design/asp_pkg.sv @@
// shared types, tables and constants for the affine sprite pixel address block
package asp_pkg;

   // defaults and fixed widths
   localparam int SCREEN_W_DEFAULT = 240;
   localparam int REQ_DATA_W       = 120;
   localparam int RSP_DATA_W       = 40;
   localparam int CSR_INDEX_W      = 1;
   localparam int CSR_DATA_W       = 1;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] REG_SPRITES_ENABLED     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_LINEAR_TILE_MAPPING = 1'd1;

   // pixel select codes
   localparam logic [1:0] SEL_BYTE = 2'd0;
   localparam logic [1:0] SEL_LOW  = 2'd1;
   localparam logic [1:0] SEL_HIGH = 2'd2;

   // tile data starts at this byte address
   localparam logic [16:0] VRAM_BASE = 17'h10000;

   // sprite width and height in pixels by shape and size; unused codes give zero
   localparam logic [6:0] WIDTH_TAB [16] = '{
      7'd8, 7'd16, 7'd32, 7'd64, 7'd16, 7'd32, 7'd32, 7'd64,
      7'd8, 7'd8,  7'd16, 7'd32, 7'd0,  7'd0,  7'd0,  7'd0};
   localparam logic [6:0] HEIGHT_TAB [16] = '{
      7'd8, 7'd16, 7'd32, 7'd64, 7'd8,  7'd8,  7'd16, 7'd32,
      7'd16, 7'd32, 7'd32, 7'd64, 7'd0, 7'd0,  7'd0,  7'd0};

   // attributes that ride along the whole pipe
   typedef struct packed {
      logic       hflip;     // only set for non-affine sprites
      logic       vflip;     // only set for non-affine sprites
      logic       c256;
      logic [6:0] sw;
      logic [6:0] sh;
      logic [1:0] wlog;      // log2 of width in tiles
      logic [7:0] sx;
      logic [9:0] tile;
      logic [3:0] bank;
   } attr_type;

   // after decode
   typedef struct packed {
      logic        ok;
      attr_type    attr;
      logic [7:0]  dx;
      logic [7:0]  dy;
      logic [15:0] pa;
      logic [15:0] pb;
      logic [15:0] pc;
      logic [15:0] pd;
   } dec_type;

   // after the multipliers
   typedef struct packed {
      logic        ok;
      attr_type    attr;
      logic [23:0] pax;
      logic [23:0] pby;
      logic [23:0] pcx;
      logic [23:0] pdy;
   } prod_type;

   // after the sums and range check
   typedef struct packed {
      logic       ok;
      attr_type   attr;
      logic [5:0] mx;
      logic [5:0] my;
   } map_type;

   // result fields
   typedef struct packed {
      logic        pixel_valid;
      logic [7:0]  screen_x;
      logic [16:0] vram_addr;
      logic [1:0]  pixel_select;
      logic [7:0]  palette_base;
   } res_type;

endpackage

@@ design/asp_decode.sv @@
// stage 1: size decode, window and screen tests, centered offsets, matrix select
module asp_decode #(
   parameter int SCREEN_W = asp_pkg::SCREEN_W_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           enable,
   input  logic                           in_valid,
   input  logic [asp_pkg::REQ_DATA_W-1:0] in_data,
   input  logic                           sprites_enabled,
   output logic                           out_valid,
   output asp_pkg::dec_type               out_stage
);
   import asp_pkg::*;

   localparam logic [10:0] ScreenLimit = 11'(SCREEN_W);

   logic [4:0]  flags;
   logic [3:0]  size_code;
   logic [8:0]  pos_x;
   logic [7:0]  pos_y;
   logic [7:0]  scan_line;
   logic [6:0]  column;
   logic        affine;
   logic        dbl;
   logic [6:0]  sw;
   logic [6:0]  sh;
   logic [7:0]  ww;
   logic [7:0]  wh;
   logic [7:0]  row;
   logic [9:0]  sx_full;
   logic        on_screen;
   logic        valid_ff;
   dec_type     stage_ff;
   dec_type     stage_in;

   // unpack the beat
   assign flags     = in_data[4:0];
   assign size_code = in_data[8:5];
   assign pos_x     = in_data[17:9];
   assign pos_y     = in_data[25:18];
   assign scan_line = in_data[107:100];
   assign column    = in_data[114:108];
   assign affine    = flags[0];
   assign dbl       = flags[1];

   // window size, doubled for double-size affine sprites
   assign sw  = WIDTH_TAB[size_code];
   assign sh  = HEIGHT_TAB[size_code];
   assign ww  = (affine && dbl) ? {sw, 1'b0} : {1'b0, sw};
   assign wh  = (affine && dbl) ? {sh, 1'b0} : {1'b0, sh};
   assign row = scan_line - pos_y;

   // screen column
   assign sx_full   = {pos_x[8], pos_x} + {3'b000, column};
   assign on_screen = !sx_full[9] && ({1'b0, sx_full} < ScreenLimit);

   always_comb begin
      stage_in.ok = sprites_enabled && (sw != 7'd0) && !(!affine && dbl)
                    && ({1'b0, column} < ww) && (row < wh) && on_screen;
      stage_in.attr.hflip = !affine && flags[2];
      stage_in.attr.vflip = !affine && flags[3];
      stage_in.attr.c256  = flags[4];
      stage_in.attr.sw    = sw;
      stage_in.attr.sh    = sh;
      stage_in.attr.wlog  = sw[6] ? 2'd3 : (sw[5] ? 2'd2 : (sw[4] ? 2'd1 : 2'd0));
      stage_in.attr.sx    = sx_full[7:0];
      stage_in.attr.tile  = in_data[35:26];
      stage_in.attr.bank  = in_data[118:115];
      // offsets from the window center; in range whenever the pixel is inside
      stage_in.dx = {1'b0, column} - {1'b0, ww[7:1]};
      stage_in.dy = row - {1'b0, wh[7:1]};
      // identity matrix for regular sprites
      if (affine) begin
         stage_in.pa = in_data[51:36];
         stage_in.pb = in_data[67:52];
         stage_in.pc = in_data[83:68];
         stage_in.pd = in_data[99:84];
      end else begin
         stage_in.pa = 16'd256;
         stage_in.pb = 16'd0;
         stage_in.pc = 16'd0;
         stage_in.pd = 16'd256;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
endmodule

@@ design/asp_mult.sv @@
// stage 2: the four matrix products
module asp_mult (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  asp_pkg::dec_type  in_stage,
   output logic              out_valid,
   output asp_pkg::prod_type out_stage
);
   import asp_pkg::*;

   logic     valid_ff;
   prod_type stage_ff;
   prod_type stage_in;

   // signed 16 by 8 products
   always_comb begin
      stage_in.ok   = in_stage.ok;
      stage_in.attr = in_stage.attr;
      stage_in.pax  = 24'($signed(in_stage.pa) * $signed(in_stage.dx));
      stage_in.pby  = 24'($signed(in_stage.pb) * $signed(in_stage.dy));
      stage_in.pcx  = 24'($signed(in_stage.pc) * $signed(in_stage.dx));
      stage_in.pdy  = 24'($signed(in_stage.pd) * $signed(in_stage.dy));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
endmodule

@@ design/asp_sum.sv @@
// stage 3: texture coordinates, integer part and bounds test
module asp_sum (
   input  logic              clock,
   input  logic              reset,
   input  logic              enable,
   input  logic              in_valid,
   input  asp_pkg::prod_type in_stage,
   output logic              out_valid,
   output asp_pkg::map_type  out_stage
);
   import asp_pkg::*;

   logic [24:0] sum_x;
   logic [24:0] sum_y;
   logic        in_x;
   logic        in_y;
   logic        valid_ff;
   map_type     stage_ff;
   map_type     stage_in;

   // 8.8 coordinates plus the sprite center
   assign sum_x = {in_stage.pax[23], in_stage.pax} + {in_stage.pby[23], in_stage.pby}
                  + {11'd0, in_stage.attr.sw, 7'd0};
   assign sum_y = {in_stage.pcx[23], in_stage.pcx} + {in_stage.pdy[23], in_stage.pdy}
                  + {11'd0, in_stage.attr.sh, 7'd0};

   // integer part is bits 24:8; must be non-negative and below the size
   assign in_x = !sum_x[24] && (sum_x[23:8] < {9'd0, in_stage.attr.sw});
   assign in_y = !sum_y[24] && (sum_y[23:8] < {9'd0, in_stage.attr.sh});

   always_comb begin
      stage_in.ok   = in_stage.ok && in_x && in_y;
      stage_in.attr = in_stage.attr;
      stage_in.mx   = sum_x[13:8];
      stage_in.my   = sum_y[13:8];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         stage_ff <= stage_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_stage = stage_ff;
endmodule

@@ design/asp_address.sv @@
// stage 4: flips, tile layout and byte address; holds the result register
module asp_address (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  logic             in_valid,
   input  asp_pkg::map_type in_stage,
   input  logic             linear_tile_mapping,
   output logic             out_valid,
   output asp_pkg::res_type out_result
);
   import asp_pkg::*;

   logic [5:0]  mx_f;
   logic [5:0]  my_f;
   logic [2:0]  tx;
   logic [2:0]  ty;
   logic [2:0]  cx;
   logic [2:0]  cy;
   logic [5:0]  tile_num;
   logic [12:0] tile_off;
   logic [5:0]  intra;
   logic [16:0] addr;
   logic        valid_ff;
   res_type     result_ff;
   res_type     result_in;

   // a flip over a power-of-two size is an xor with size minus one
   assign mx_f = in_stage.attr.hflip ? (in_stage.mx ^ (in_stage.attr.sw[5:0] - 6'd1))
                                     : in_stage.mx;
   assign my_f = in_stage.attr.vflip ? (in_stage.my ^ (in_stage.attr.sh[5:0] - 6'd1))
                                     : in_stage.my;
   assign tx = mx_f[5:3];
   assign cx = mx_f[2:0];
   assign ty = my_f[5:3];
   assign cy = my_f[2:0];

   // tile offset for the two layouts
   assign tile_num = 6'({3'b000, ty} << in_stage.attr.wlog) + {3'b000, tx};
   always_comb begin
      if (linear_tile_mapping) begin
         tile_off = in_stage.attr.c256 ? {1'b0, tile_num, 6'd0} : {2'b00, tile_num, 5'd0};
      end else begin
         tile_off = {ty, 10'd0} + (in_stage.attr.c256 ? {4'd0, tx, 6'd0} : {5'd0, tx, 5'd0});
      end
   end

   // byte inside the tile
   assign intra = in_stage.attr.c256 ? {cy, cx} : {1'b0, cy, cx[2:1]};
   assign addr  = VRAM_BASE + {2'b00, in_stage.attr.tile, 5'd0} + {4'd0, tile_off}
                  + {11'd0, intra};

   always_comb begin
      result_in = '0;
      if (in_stage.ok) begin
         result_in.pixel_valid = 1'b1;
         result_in.screen_x    = in_stage.attr.sx;
         result_in.vram_addr   = addr;
         if (in_stage.attr.c256) begin
            result_in.pixel_select = SEL_BYTE;
            result_in.palette_base = 8'd0;
         end else begin
            result_in.pixel_select = cx[0] ? SEL_HIGH : SEL_LOW;
            result_in.palette_base = {in_stage.attr.bank, 4'd0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
      if (enable) begin
         result_ff <= result_in;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;
endmodule

@@ design/affine_sprite_pixel_address_top.sv @@
// top level of the affine sprite pixel address pipeline
// One beat in per cycle while the output does not stall, one result beat out per input
// beat, in order. The work runs through four register stages (decode, multiply, sum
// and range check, address), in that order; the four 16x8 multipliers share one stage.
// rsp_tready low holds the pipe only where it is full: empty stages keep filling, and
// req_tready drops once all four hold a beat. Configuration writes take effect at once
// and must be made while the pipe is empty; the block itself does not enforce this.
module affine_sprite_pixel_address_top #(
   parameter int SCREEN_W = asp_pkg::SCREEN_W_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   // sprite_flags, size_code, pos_x, pos_y, tile_index, mat_a, mat_b, mat_c, mat_d,
   // scan_line, column, palette_bank, zero pad
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [asp_pkg::REQ_DATA_W-1:0]  req_tdata,
   // screen_x, vram_addr, pixel_select, palette_base, zero pad
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [asp_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // pixel_valid
   output logic                            rsp_tuser,
   input  logic                            csr_we,
   input  logic [asp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [asp_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import asp_pkg::*;

   logic     sprites_enabled_ff;
   logic     linear_mapping_ff;
   logic     v1, v2, v3, v4;
   logic     en1, en2, en3, en4;
   dec_type  s1;
   prod_type s2;
   map_type  s3;
   res_type  res;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sprites_enabled_ff <= 1'b0;
         linear_mapping_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SPRITES_ENABLED:     sprites_enabled_ff <= csr_wdata[0];
            REG_LINEAR_TILE_MAPPING: linear_mapping_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // a stage moves when it is empty or the next one moves
   assign en4 = !v4 || rsp_tready;
   assign en3 = !v3 || en4;
   assign en2 = !v2 || en3;
   assign en1 = !v1 || en2;
   assign req_tready = en1;

   asp_decode #(.SCREEN_W(SCREEN_W)) u_decode (
      .clock           (clock),
      .reset           (reset),
      .enable          (en1),
      .in_valid        (req_tvalid),
      .in_data         (req_tdata),
      .sprites_enabled (sprites_enabled_ff),
      .out_valid       (v1),
      .out_stage       (s1)
   );

   asp_mult u_mult (
      .clock     (clock),
      .reset     (reset),
      .enable    (en2),
      .in_valid  (v1),
      .in_stage  (s1),
      .out_valid (v2),
      .out_stage (s2)
   );

   asp_sum u_sum (
      .clock     (clock),
      .reset     (reset),
      .enable    (en3),
      .in_valid  (v2),
      .in_stage  (s2),
      .out_valid (v3),
      .out_stage (s3)
   );

   asp_address u_address (
      .clock               (clock),
      .reset               (reset),
      .enable              (en4),
      .in_valid            (v3),
      .in_stage            (s3),
      .linear_tile_mapping (linear_mapping_ff),
      .out_valid           (v4),
      .out_result          (res)
   );

   // result beat
   assign rsp_tvalid = v4;
   assign rsp_tuser  = res.pixel_valid;
   assign rsp_tdata  = {5'd0, res.palette_base, res.pixel_select, res.vram_addr,
                        res.screen_x};
endmodule

@@ design/asp_checker.sv @@
// port-level checks for the affine sprite pixel address block, bound to the top level
module asp_checker #(
   parameter int SCREEN_W = 240
) (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [39:0]  rsp_tdata,
   input logic         rsp_tuser
);

   // a held result does not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a missed pixel carries all-zero fields
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 40'd0)
      else $error("invalid pixel with nonzero fields");

   // a hit lands on screen and inside tile memory
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[24] == 1'b1)
                                  && ({24'd0, rsp_tdata[7:0]} < 32'(SCREEN_W)))
      else $error("pixel address or column out of range");

   // select code and palette base agree on color mode
   a_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> (rsp_tdata[26:25] != 2'd3) && (rsp_tdata[30:27] == 4'd0)
                                  && ((rsp_tdata[26:25] != 2'd0) || (rsp_tdata[34:31] == 4'd0)))
      else $error("pixel select and palette base disagree");

endmodule

bind affine_sprite_pixel_address_top asp_checker #(.SCREEN_W(SCREEN_W)) u_asp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
